/* hw/rtl/lgre_pkg.sv */
package lgre_pkg;

   localparam int LGRE_ROW_W        = 64;
   localparam int LGRE_CFG_W        = 7;
   localparam int LGRE_MAX_COLS_DEF = 64;
   localparam int LGRE_QUEUE_DEPTH  = 4;
   localparam logic [LGRE_CFG_W-1:0] LGRE_COLS_RESET = LGRE_CFG_W'(64);

   // masked cell values one column hands to its neighbors
   typedef struct packed {
      logic up;
      logic mid;
      logic dn;
   } nbr_type;

   // per-column results of both generations a cell can produce
   typedef struct packed {
      logic gen_mid;
      logic chg_mid;
      logic gen_last;
      logic chg_last;
   } cell_out_type;

   typedef struct packed {
      logic [LGRE_ROW_W-1:0] next_row;
      logic                  last_of_frame;
      logic                  frame_stable;
   } rsp_entry_type;

endpackage

/* hw/rtl/lgre_ifs.sv */
interface lgre_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] row_cells;
   logic        frame_last_row;

   modport source (output valid, output row_cells, output frame_last_row, input ready);
   modport sink (input valid, input row_cells, input frame_last_row, output ready);
endinterface

interface lgre_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] next_row;
   logic        last_of_frame;
   logic        frame_stable;

   modport source (output valid, output next_row, output last_of_frame,
                   output frame_stable, input ready);
   modport sink (input valid, input next_row, input last_of_frame,
                 input frame_stable, output ready);
endinterface

interface lgre_csr_if;
   logic       valid;
   logic       ready;
   logic [6:0] cols_in_use;

   modport source (output valid, output cols_in_use, input ready);
   modport sink (input valid, input cols_in_use, output ready);
endinterface

/* hw/rtl/lgre_cell.sv */
module lgre_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  col_en,
   input  logic                  shift_en,
   input  logic                  clear,
   input  logic                  row_bit,
   input  lgre_pkg::nbr_type     lo_nbr,
   input  lgre_pkg::nbr_type     hi_nbr,
   output lgre_pkg::nbr_type     own_nbr,
   output lgre_pkg::cell_out_type cell_out
);
   import lgre_pkg::*;

   logic       above_ff, above_in;
   logic       middle_ff, middle_in;
   logic       up, mid, dn;
   logic [3:0] cnt_mid;
   logic [3:0] cnt_last;

   always_comb begin
      up  = above_ff & col_en;
      mid = middle_ff & col_en;
      dn  = row_bit & col_en;
   end

   assign own_nbr = '{up: up, mid: mid, dn: dn};

   // held middle row with the incoming row below it
   assign cnt_mid = 4'(lo_nbr.up) + 4'(up) + 4'(hi_nbr.up) + 4'(lo_nbr.mid)
                  + 4'(hi_nbr.mid) + 4'(lo_nbr.dn) + 4'(dn) + 4'(hi_nbr.dn);
   // incoming row as the last of the frame, dead row below
   assign cnt_last = 4'(lo_nbr.mid) + 4'(mid) + 4'(hi_nbr.mid)
                   + 4'(lo_nbr.dn) + 4'(hi_nbr.dn);

   always_comb begin
      cell_out.gen_mid  = col_en & ((cnt_mid == 4'd3) | (mid & (cnt_mid == 4'd2)));
      cell_out.chg_mid  = cell_out.gen_mid ^ mid;
      cell_out.gen_last = col_en & ((cnt_last == 4'd3) | (dn & (cnt_last == 4'd2)));
      cell_out.chg_last = cell_out.gen_last ^ dn;
   end

   // held rows keep their masked entry bits; the width mask applies again on use
   always_comb begin
      above_in  = above_ff;
      middle_in = middle_ff;
      if (shift_en) begin
         above_in  = clear ? 1'b0 : middle_ff;
         middle_in = clear ? 1'b0 : dn;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         above_ff  <= 1'b0;
         middle_ff <= 1'b0;
      end else begin
         above_ff  <= above_in;
         middle_ff <= middle_in;
      end
   end

endmodule

/* hw/rtl/lgre_queue.sv */
module lgre_queue #(
   parameter int DEPTH = lgre_pkg::LGRE_QUEUE_DEPTH
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_a_valid,
   input  lgre_pkg::rsp_entry_type wr_a,
   input  logic                    wr_b_valid,
   input  lgre_pkg::rsp_entry_type wr_b,
   output logic                    room_two,
   lgre_rsp_if.source              rsp_chan
);
   import lgre_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rsp_entry_type        entry_ff [DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [PTR_W-1:0]     wr_next;
   logic [1:0]           n_wr;
   logic                 pop;
   rsp_entry_type        first_entry;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
      return r;
   endfunction

   assign pop         = rsp_chan.valid & rsp_chan.ready;
   assign n_wr        = 2'(wr_a_valid) + 2'(wr_b_valid);
   assign first_entry = wr_a_valid ? wr_a : wr_b;
   assign wr_next     = ptr_inc(wr_ptr_ff);
   assign room_two    = (count_ff <= CNT_W'(DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (n_wr == 2'd1) begin
         wr_ptr_in = wr_next;
      end else if (n_wr == 2'd2) begin
         wr_ptr_in = ptr_inc(wr_next);
      end
      if (pop) begin
         rd_ptr_in = ptr_inc(rd_ptr_ff);
      end
      count_in = count_ff + CNT_W'(n_wr) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (n_wr != 2'd0) begin
         entry_ff[wr_ptr_ff] <= first_entry;
      end
      if (n_wr == 2'd2) begin
         entry_ff[wr_next] <= wr_b;
      end
   end

   assign rsp_chan.valid         = (count_ff != '0);
   assign rsp_chan.next_row      = entry_ff[rd_ptr_ff].next_row;
   assign rsp_chan.last_of_frame = entry_ff[rd_ptr_ff].last_of_frame;
   assign rsp_chan.frame_stable  = entry_ff[rd_ptr_ff].frame_stable;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (wr_a_valid && wr_b_valid) |-> room_two)
      else $error("queue written with two entries without room");

   a_pop_only_drains: assert property (@(posedge clock) disable iff (reset)
      (pop && n_wr == 2'd0) |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("queue count did not drop on a lone pop");

endmodule

/* hw/rtl/life_generation_row_engine.sv */
// Life (B3/S23) row engine. Rows of a frame enter top first, one request per
// cycle, bit c of row_cells being column c. Each request after the first of a
// frame yields the next generation of the row before it; a request marked
// frame_last_row also yields its own next row, so it produces two results
// (one for a one-row frame), the last one carrying last_of_frame and
// frame_stable. Results are in the result queue from the cycle after the request
// is taken and leave that four-entry queue at one per cycle; requests are taken
// while that queue holds at most two entries, so with the result side always
// ready the block sustains one row per cycle, and each frame's last row adds one
// extra result. The grid is a row of MAX_COLS column cells that each hold their
// column of the two buffered rows and trade them with their neighbors.
// Columns at or above cols_in_use read as dead and come out zero; write
// cols_in_use only while no results are pending.
module life_generation_row_engine #(
   parameter int MAX_COLS = lgre_pkg::LGRE_MAX_COLS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   lgre_req_if.sink   req_chan,
   lgre_rsp_if.source rsp_chan,
   lgre_csr_if.sink   csr_chan
);
   import lgre_pkg::*;

   logic [LGRE_CFG_W-1:0] cols_ff, cols_in;
   logic                  have_mid_ff, have_mid_in;
   logic                  unchanged_ff, unchanged_in;

   nbr_type               nbr [MAX_COLS];
   cell_out_type          cell_res [MAX_COLS];
   logic [MAX_COLS-1:0]   gen_mid_vec, gen_last_vec;
   logic [MAX_COLS-1:0]   chg_mid_vec, chg_last_vec;

   logic                  accept;
   logic                  room_two;
   logic                  mid_changed;
   logic                  stable;
   rsp_entry_type         wr_a, wr_b;

   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = room_two;
   assign accept         = req_chan.valid & req_chan.ready;

   for (genvar c = 0; c < MAX_COLS; c++) begin : g_col
      nbr_type lo_nbr;
      nbr_type hi_nbr;

      if (c == 0) begin : g_lo_edge
         assign lo_nbr = '0;
      end else begin : g_lo
         assign lo_nbr = nbr[c-1];
      end
      if (c == MAX_COLS - 1) begin : g_hi_edge
         assign hi_nbr = '0;
      end else begin : g_hi
         assign hi_nbr = nbr[c+1];
      end

      lgre_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .col_en   (cols_ff > LGRE_CFG_W'(c)),
         .shift_en (accept),
         .clear    (req_chan.frame_last_row),
         .row_bit  (req_chan.row_cells[c]),
         .lo_nbr   (lo_nbr),
         .hi_nbr   (hi_nbr),
         .own_nbr  (nbr[c]),
         .cell_out (cell_res[c])
      );

      assign gen_mid_vec[c]  = cell_res[c].gen_mid;
      assign chg_mid_vec[c]  = cell_res[c].chg_mid;
      assign gen_last_vec[c] = cell_res[c].gen_last;
      assign chg_last_vec[c] = cell_res[c].chg_last;
   end

   assign mid_changed = have_mid_ff & (|chg_mid_vec);
   assign stable      = unchanged_ff & ~mid_changed & ~(|chg_last_vec);

   always_comb begin
      wr_a.next_row      = LGRE_ROW_W'(gen_mid_vec);
      wr_a.last_of_frame = 1'b0;
      wr_a.frame_stable  = 1'b0;
      wr_b.next_row      = LGRE_ROW_W'(gen_last_vec);
      wr_b.last_of_frame = 1'b1;
      wr_b.frame_stable  = stable;
   end

   always_comb begin
      cols_in      = cols_ff;
      have_mid_in  = have_mid_ff;
      unchanged_in = unchanged_ff;
      if (csr_chan.valid) begin
         cols_in = csr_chan.cols_in_use;
      end
      if (accept) begin
         have_mid_in  = ~req_chan.frame_last_row;
         unchanged_in = req_chan.frame_last_row | (unchanged_ff & ~mid_changed);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff      <= LGRE_COLS_RESET;
         have_mid_ff  <= 1'b0;
         unchanged_ff <= 1'b1;
      end else begin
         cols_ff      <= cols_in;
         have_mid_ff  <= have_mid_in;
         unchanged_ff <= unchanged_in;
      end
   end

   lgre_queue #(
      .DEPTH (LGRE_QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .wr_a_valid (accept & have_mid_ff),
      .wr_a       (wr_a),
      .wr_b_valid (accept & req_chan.frame_last_row),
      .wr_b       (wr_b),
      .room_two   (room_two),
      .rsp_chan   (rsp_chan)
   );

   a_frame_end_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && req_chan.frame_last_row) |=> (!have_mid_ff && unchanged_ff))
      else $error("frame state not cleared after last row");

   a_stable_only_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.frame_stable) |-> rsp_chan.last_of_frame)
      else $error("stable flag on a result that is not last of frame");

   a_change_sticks: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_chan.frame_last_row && mid_changed) |=> !unchanged_ff)
      else $error("changed row not recorded in frame state");

endmodule
